### src/vir_pkg.sv
// Package: shared constants, types and helper functions for the vector integer reduction unit.
package vir_pkg;

    localparam int DATA_W  = 64;
    localparam int OP_W    = 4;
    localparam int EW_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SUM   = 4'd0;
    localparam logic [OP_W-1:0] OP_AND   = 4'd1;
    localparam logic [OP_W-1:0] OP_OR    = 4'd2;
    localparam logic [OP_W-1:0] OP_XOR   = 4'd3;
    localparam logic [OP_W-1:0] OP_MINU  = 4'd4;
    localparam logic [OP_W-1:0] OP_MIN   = 4'd5;
    localparam logic [OP_W-1:0] OP_MAXU  = 4'd6;
    localparam logic [OP_W-1:0] OP_MAX   = 4'd7;
    localparam logic [OP_W-1:0] OP_WSUMU = 4'd8;
    localparam logic [OP_W-1:0] OP_WSUM  = 4'd9;

    // Element width codes
    localparam logic [EW_W-1:0] EW_8  = 2'd0;
    localparam logic [EW_W-1:0] EW_16 = 2'd1;
    localparam logic [EW_W-1:0] EW_32 = 2'd2;
    localparam logic [EW_W-1:0] EW_64 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_KIND       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASKED_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SCALAR  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op_kind;
        logic [EW_W-1:0]   element_width;
        logic              masked_mode;
        logic [DATA_W-1:0] start_scalar;
    } t_cfg;

    function automatic logic f_is_wide(input logic [OP_W-1:0] op);
        return (op == OP_WSUMU) || (op == OP_WSUM);
    endfunction

    function automatic logic [DATA_W-1:0] f_elem_mask(input logic [EW_W-1:0] ew);
        logic [DATA_W-1:0] m;
        unique case (ew)
            EW_8:    m = 64'h0000_0000_0000_00FF;
            EW_16:   m = 64'h0000_0000_0000_FFFF;
            EW_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = ALL_ONES;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] f_res_mask(input logic [EW_W-1:0] ew,
                                                     input logic wide);
        logic [DATA_W-1:0] m;
        if (!wide) begin
            m = f_elem_mask(ew);
        end else begin
            unique case (ew)
                EW_8:    m = 64'h0000_0000_0000_FFFF;
                EW_16:   m = 64'h0000_0000_FFFF_FFFF;
                default: m = ALL_ONES;
            endcase
        end
        return m;
    endfunction

    // Top bit of an element of the given width
    function automatic logic [DATA_W-1:0] f_sign_bit(input logic [EW_W-1:0] ew);
        logic [DATA_W-1:0] b;
        unique case (ew)
            EW_8:    b = 64'h0000_0000_0000_0080;
            EW_16:   b = 64'h0000_0000_0000_8000;
            EW_32:   b = 64'h0000_0000_8000_0000;
            default: b = 64'h8000_0000_0000_0000;
        endcase
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] f_sign_ext(input logic [DATA_W-1:0] v,
                                                     input logic [EW_W-1:0] ew);
        logic [DATA_W-1:0] r;
        unique case (ew)
            EW_8:    r = {{56{v[7]}}, v[7:0]};
            EW_16:   r = {{48{v[15]}}, v[15:0]};
            EW_32:   r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

### src/vir_elem_if.sv
// Interface: element input channel.
interface vir_elem_if;
    logic                        valid;
    logic                        ready;
    logic [vir_pkg::DATA_W-1:0]  element_value;
    logic                        elem_mask;
    logic                        last_element;

    modport source (output valid, output element_value, output elem_mask,
                    output last_element, input ready);
    modport sink   (input valid, input element_value, input elem_mask,
                    input last_element, output ready);
endinterface

### src/vir_result_if.sv
// Interface: reduction result output channel.
interface vir_result_if;
    logic                        valid;
    logic                        ready;
    logic [vir_pkg::DATA_W-1:0]  reduction_result;

    modport source (output valid, output reduction_result, input ready);
    modport sink   (input valid, input reduction_result, output ready);
endinterface

### src/vir_cfg_if.sv
// Interface: configuration register write channel.
interface vir_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vir_pkg::CFG_IDX_W-1:0]  index;
    logic [vir_pkg::DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/vir_fold.sv
// Fold datapath: combines one element into the running accumulator.
module vir_fold (
    input  vir_pkg::t_cfg               i_cfg,
    input  logic [vir_pkg::DATA_W-1:0]  i_acc,
    input  logic [vir_pkg::DATA_W-1:0]  i_element,
    input  logic                        i_mask,
    output logic [vir_pkg::DATA_W-1:0]  o_acc
);

    logic [vir_pkg::DATA_W-1:0] rmask;
    logic [vir_pkg::DATA_W-1:0] emask;
    logic [vir_pkg::DATA_W-1:0] flip;
    logic [vir_pkg::DATA_W-1:0] a;
    logic [vir_pkg::DATA_W-1:0] e;
    logic [vir_pkg::DATA_W-1:0] addend;
    logic [vir_pkg::DATA_W-1:0] sum;
    logic [vir_pkg::DATA_W-1:0] res;
    logic                       active;
    logic                       le_u;
    logic                       le_s;

    assign rmask  = vir_pkg::f_res_mask(i_cfg.element_width,
                                        vir_pkg::f_is_wide(i_cfg.op_kind));
    assign emask  = vir_pkg::f_elem_mask(i_cfg.element_width);
    assign flip   = vir_pkg::f_sign_bit(i_cfg.element_width);
    assign a      = i_acc & rmask;
    assign e      = i_element & emask;
    assign active = !i_cfg.masked_mode || i_mask;
    assign le_u   = (a <= e);
    assign le_s   = ((a ^ flip) <= (e ^ flip));
    assign addend = (i_cfg.op_kind == vir_pkg::OP_WSUM)
                  ? vir_pkg::f_sign_ext(e, i_cfg.element_width) : e;
    assign sum    = a + addend;

    always_comb begin
        res = a;
        if (active) begin
            case (i_cfg.op_kind) inside
                vir_pkg::OP_SUM, vir_pkg::OP_WSUMU, vir_pkg::OP_WSUM: res = sum;
                vir_pkg::OP_AND:  res = a & e;
                vir_pkg::OP_OR:   res = a | e;
                vir_pkg::OP_XOR:  res = a ^ e;
                vir_pkg::OP_MINU: res = le_u ? a : e;
                vir_pkg::OP_MIN:  res = le_s ? a : e;
                vir_pkg::OP_MAXU: res = le_u ? e : a;
                vir_pkg::OP_MAX:  res = le_s ? e : a;
                default:          res = a;
            endcase
        end
    end

    assign o_acc = res & rmask;

endmodule

### src/vector_integer_reduction_unit.sv
// Top level: vector integer reduction unit with input register and result register.
//
//  channel   dir  payload                                    notes
//  i_elem    in   element_value[64], elem_mask, last_element one element per transaction
//  o_result  out  reduction_result[64]                       one per last element
//  i_cfg     in   index[2], data[64]                         always ready
//
// One element per cycle, but for the stall below; a result goes out via the result register.
// The accumulator loop (one add, compare or logic op) sets the clock period.
// Synchronous active-low reset clears config, valid flags and the busy flag.
// A result not yet taken holds the next last element in the input register, which
// then blocks the input; elements that are not last keep flowing meanwhile.
module vector_integer_reduction_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vir_elem_if.sink             i_elem,
    vir_result_if.source         o_result,
    vir_cfg_if.sink              i_cfg
);

    vir_pkg::t_cfg               r_cfg;
    logic                        r_in_valid;
    logic [vir_pkg::DATA_W-1:0]  r_in_value;
    logic                        r_in_mask;
    logic                        r_in_last;
    logic                        r_busy;
    logic [vir_pkg::DATA_W-1:0]  r_acc;
    logic                        r_out_valid;
    logic [vir_pkg::DATA_W-1:0]  r_out_data;

    logic [vir_pkg::DATA_W-1:0]  n_acc;
    logic [vir_pkg::DATA_W-1:0]  acc_base;
    logic                        advance;
    logic                        in_take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vir_pkg::CFG_OP_KIND:       r_cfg.op_kind <= i_cfg.data[vir_pkg::OP_W-1:0];
                vir_pkg::CFG_ELEMENT_WIDTH: r_cfg.element_width <= i_cfg.data[vir_pkg::EW_W-1:0];
                vir_pkg::CFG_MASKED_MODE:   r_cfg.masked_mode <= i_cfg.data[0];
                vir_pkg::CFG_START_SCALAR:  r_cfg.start_scalar <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign advance = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign i_elem.ready = !r_in_valid || advance;
    assign in_take = i_elem.valid && i_elem.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_value <= i_elem.element_value;
            r_in_mask  <= i_elem.elem_mask;
            r_in_last  <= i_elem.last_element;
        end
    end

    // New vector starts from the start scalar
    assign acc_base = r_busy ? r_acc : r_cfg.start_scalar;

    vir_fold u_fold (
        .i_cfg     (r_cfg),
        .i_acc     (acc_base),
        .i_element (r_in_value),
        .i_mask    (r_in_mask),
        .o_acc     (n_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_busy <= !r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_acc <= n_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= n_acc;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.reduction_result = r_out_data;

endmodule
